// ===== rtl/erm_pkg.sv =====
// ----------------------------------------------------------------------------
// erm_pkg: shared types, constants and microcode for the rotation matrix builder
// Holds the sine polynomial constants, the baseline orientation, the
// scratch map and the micro-op program run by the shared arithmetic unit.
// ----------------------------------------------------------------------------
package erm_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int COEF_BITS_DEF  = 16;
	localparam int COEF_BITS_MAX  = 24;
	localparam int WORD_W         = 34;
	localparam int ADDR_W         = 4;
	localparam int MAG_W          = 31;
	localparam int NUM_SINES      = 6;
	localparam int SINE_STEPS     = 6;
	localparam int NUM_MAT        = 20;
	localparam int NUM_UOPS       = NUM_SINES * SINE_STEPS + NUM_MAT;
	localparam int NUM_ENTRIES    = 9;

	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic signed [WORD_W-1:0] word_t;

	localparam word_t K_SIN_A   = 34'sd1686629713;
	localparam word_t K_SIN_B   = 34'sd688904866;
	localparam word_t K_SIN_C   = 34'sd76016977;
	localparam logic [MAG_W-1:0] Q30_ONE = 31'd1073741824;
	localparam logic signed [31:0] BASE_DEPTH_RST = -32'sd6464548;

	// scratch map: sines overwrite their folded phases
	localparam addr_t A_SR  = 4'd0;
	localparam addr_t A_CR  = 4'd1;
	localparam addr_t A_SB  = 4'd2;
	localparam addr_t A_CB  = 4'd3;
	localparam addr_t A_SG  = 4'd4;
	localparam addr_t A_CG  = 4'd5;
	localparam addr_t A_T0  = 4'd6;
	localparam addr_t A_T1  = 4'd7;
	localparam addr_t A_M0  = 4'd8;
	localparam addr_t A_M1  = 4'd9;
	localparam addr_t A_M2  = 4'd10;
	localparam addr_t A_M4  = 4'd11;
	localparam addr_t A_M5  = 4'd12;
	localparam addr_t A_M6  = 4'd13;
	localparam addr_t A_M7  = 4'd14;
	localparam addr_t A_M8  = 4'd15;

	typedef enum logic [1:0] {
		OP_MULT,
		OP_MULR,
		OP_SUB,
		OP_ADD
	} op_t;

	typedef enum logic [2:0] {
		SRC_MEM,
		SRC_KA,
		SRC_KB,
		SRC_KC,
		SRC_ZERO
	} src_t;

	typedef struct packed {
		op_t        op;
		src_t       a_src;
		addr_t      a_addr;
		addr_t      b_addr;
		addr_t      dst;
		logic       use_flag;
		logic [2:0] flag_idx;
	} uop_t;

	typedef struct packed {
		logic en;
		op_t  op;
		src_t a_src;
		logic neg;
	} alu_ctl_t;

	function automatic uop_t mk(input op_t op, input src_t s, input addr_t a,
			input addr_t b, input addr_t d);
		uop_t u;
		u.op       = op;
		u.a_src    = s;
		u.a_addr   = a;
		u.b_addr   = b;
		u.dst      = d;
		u.use_flag = 1'b0;
		u.flag_idx = 3'd0;
		return u;
	endfunction

	// z*(A - z^2*(B - C*z^2)) in six steps for sine k
	function automatic uop_t sine_uop(input logic [2:0] k, input logic [2:0] s);
		uop_t  u;
		addr_t z;
		z = addr_t'(k);
		case (s)
			3'd1:    u = mk(OP_MULT, SRC_KC,  A_T0, A_T0, A_T1);
			3'd2:    u = mk(OP_SUB,  SRC_KB,  A_T1, A_T1, A_T1);
			3'd3:    u = mk(OP_MULT, SRC_MEM, A_T1, A_T0, A_T1);
			3'd4:    u = mk(OP_SUB,  SRC_KA,  A_T1, A_T1, A_T1);
			3'd5: begin
				u = mk(OP_MULT, SRC_MEM, A_T1, z, z);
				u.use_flag = 1'b1;
				u.flag_idx = k;
			end
			default: u = mk(OP_MULT, SRC_MEM, z, z, A_T0);
		endcase
		return u;
	endfunction

	function automatic uop_t mat_uop(input logic [4:0] j);
		uop_t u;
		case (j)
			5'd0:    u = mk(OP_MULR, SRC_MEM,  A_SG, A_CR, A_T0);
			5'd1:    u = mk(OP_MULR, SRC_MEM,  A_SG, A_SR, A_T1);
			5'd2:    u = mk(OP_MULR, SRC_MEM,  A_CB, A_CG, A_M0);
			5'd3:    u = mk(OP_MULR, SRC_MEM,  A_CB, A_T0, A_M1);
			5'd4:    u = mk(OP_MULR, SRC_MEM,  A_SB, A_SR, A_M2);
			5'd5:    u = mk(OP_SUB,  SRC_MEM,  A_M2, A_M1, A_M1);
			5'd6:    u = mk(OP_MULR, SRC_MEM,  A_CB, A_T1, A_M2);
			5'd7:    u = mk(OP_MULR, SRC_MEM,  A_SB, A_CR, A_M4);
			5'd8:    u = mk(OP_ADD,  SRC_MEM,  A_M2, A_M4, A_M2);
			5'd9:    u = mk(OP_MULR, SRC_MEM,  A_CG, A_CR, A_M4);
			5'd10:   u = mk(OP_MULR, SRC_MEM,  A_CG, A_SR, A_M5);
			5'd11:   u = mk(OP_SUB,  SRC_ZERO, A_M5, A_M5, A_M5);
			5'd12:   u = mk(OP_MULR, SRC_MEM,  A_SB, A_CG, A_M6);
			5'd13:   u = mk(OP_SUB,  SRC_ZERO, A_M6, A_M6, A_M6);
			5'd14:   u = mk(OP_MULR, SRC_MEM,  A_SB, A_T0, A_M7);
			5'd15:   u = mk(OP_MULR, SRC_MEM,  A_CB, A_SR, A_M8);
			5'd16:   u = mk(OP_ADD,  SRC_MEM,  A_M7, A_M8, A_M7);
			5'd17:   u = mk(OP_MULR, SRC_MEM,  A_SB, A_T1, A_M8);
			5'd18:   u = mk(OP_MULR, SRC_MEM,  A_CB, A_CR, A_T0);
			5'd19:   u = mk(OP_SUB,  SRC_MEM,  A_T0, A_M8, A_M8);
			default: u = mk(OP_MULR, SRC_MEM,  A_SG, A_CR, A_T0);
		endcase
		return u;
	endfunction

	// scratch location of matrix entry j, row-major
	function automatic addr_t entry_addr(input logic [3:0] j);
		addr_t a;
		case (j)
			4'd1:    a = A_M1;
			4'd2:    a = A_M2;
			4'd3:    a = A_SG;
			4'd4:    a = A_M4;
			4'd5:    a = A_M5;
			4'd6:    a = A_M6;
			4'd7:    a = A_M7;
			4'd8:    a = A_M8;
			default: a = A_M0;
		endcase
		return a;
	endfunction

	function automatic word_t baseline_q30(input int i);
		word_t v;
		case (i)
			0:       v =  34'sd898767165;
			1:       v = -34'sd388418181;
			2:       v =  34'sd440761377;
			3:       v =  34'sd65996543;
			4:       v =  34'sd867229703;
			5:       v =  34'sd629665613;
			6:       v = -34'sd583766848;
			7:       v = -34'sd499965547;
			default: v =  34'sd749781503;
		endcase
		return v;
	endfunction

	// Q30 to Q1.(cb-2): round half away from zero, saturate to +-1
	function automatic logic [COEF_BITS_MAX-1:0] to_coef(input word_t v, input int cb);
		logic [WORD_W-1:0] mag;
		logic [WORD_W-1:0] r;
		logic [WORD_W-1:0] lim;
		logic [WORD_W-1:0] s;
		mag = v[WORD_W-1] ? -v : v;
		r   = (mag + (WORD_W'(1) << (31 - cb))) >> (32 - cb);
		lim = WORD_W'(1) << (cb - 2);
		if (r > lim)
			r = lim;
		s = v[WORD_W-1] ? -r : r;
		return s[COEF_BITS_MAX-1:0];
	endfunction

endpackage

// ===== rtl/erm_ifs.sv =====
// ----------------------------------------------------------------------------
// erm channel interfaces
// Sample request, result request and configuration write channels.
// ----------------------------------------------------------------------------
interface erm_sample_if #(parameter int ANGLE_BITS = erm_pkg::ANGLE_BITS_DEF);
	logic                         valid;
	logic                         ready;
	logic signed [ANGLE_BITS-1:0] roll_angle;
	logic signed [ANGLE_BITS-1:0] pitch_angle;
	logic signed [ANGLE_BITS-1:0] yaw_angle;
	logic                         sticker_present;
	logic signed [ANGLE_BITS-1:0] user_rotation;
	logic signed [31:0]           user_scaling;

	modport source (output valid, roll_angle, pitch_angle, yaw_angle, sticker_present,
		user_rotation, user_scaling, input ready);
	modport sink (input valid, roll_angle, pitch_angle, yaw_angle, sticker_present,
		user_rotation, user_scaling, output ready);
endinterface

interface erm_result_if #(parameter int COEF_BITS = erm_pkg::COEF_BITS_DEF);
	logic                        valid;
	logic                        ready;
	logic signed [COEF_BITS-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic signed [31:0]          depth_offset;

	modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		depth_offset, input ready);
	modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		depth_offset, output ready);
endinterface

interface erm_cfg_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== rtl/euler_rotation_matrix_builder_unit.sv =====
// ----------------------------------------------------------------------------
// euler_rotation_matrix_builder_unit: Euler angles to rotation matrix
// Builds R = Ry(-pitch)*Rz(user_rotation-yaw)*Rx(roll) and a saturated depth
// with one shared multiplier stepped through a 56-op micro-program.
// ----------------------------------------------------------------------------
// Flow: a sample with the sticker flag set loads six folded phases, runs
//   the 56 ops through the shared multiplier and scratch read port (read,
//   multiply, write back), waits until any pending result is taken, then
//   converts the nine entries. A flag-clear sample also waits for any
//   pending result, then repeats the stored result. One request in flight;
//   sample.ready is low until the result is issued. Reset loads the baseline.
module euler_rotation_matrix_builder_unit #(
	parameter int ANGLE_BITS = erm_pkg::ANGLE_BITS_DEF,
	parameter int COEF_BITS  = erm_pkg::COEF_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	erm_sample_if.sink    sample,
	erm_result_if.source  result,
	erm_cfg_if.sink       cfg
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_RUN,
		S_WAIT,
		S_COPY
	} state_t;

	state_t                       state_q;
	logic [2:0]                   ld_q;
	logic [5:0]                   pc_q;
	logic [2:0]                   k_q;
	logic [2:0]                   s_q;
	logic [1:0]                   ph_q;
	logic [3:0]                   cp_q;
	logic                         upd_q;
	logic                         out_valid_q;
	logic [5:0]                   neg_q;
	logic signed [ANGLE_BITS-1:0] roll_q;
	logic signed [ANGLE_BITS-1:0] pitch_q;
	logic signed [ANGLE_BITS-1:0] gam_q;
	logic signed [31:0]           base_depth_q;
	logic signed [31:0]           depth_new_q;
	logic signed [31:0]           depth_q;
	logic [COEF_BITS-1:0]         r_q [erm_pkg::NUM_ENTRIES];
	logic [erm_pkg::COEF_BITS_MAX-1:0] rst_full [erm_pkg::NUM_ENTRIES];

	erm_pkg::uop_t     uop;
	erm_pkg::alu_ctl_t alu_ctl;
	erm_pkg::word_t    rd_a, rd_b, alu_res, wdata;
	erm_pkg::addr_t    raddr_a, raddr_b, waddr;
	logic              we;
	logic [ANGLE_BITS-1:0] ang;
	logic [31:0]       phase;
	logic [erm_pkg::MAG_W-1:0] zf, zfold;
	logic              ld_neg;
	logic [32:0]       dsum;
	logic signed [31:0] dsat;
	logic [erm_pkg::COEF_BITS_MAX-1:0] coef_full;
	logic [3:0]        wr_idx;
	logic              accept;

	genvar gi;
	generate
		for (gi = 0; gi < erm_pkg::NUM_ENTRIES; gi++) begin : g_rst
			assign rst_full[gi] = erm_pkg::to_coef(erm_pkg::baseline_q30(gi), COEF_BITS);
		end
	endgenerate

	assign accept     = sample.valid && sample.ready;
	assign sample.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;

	assign uop = (pc_q < 6'(erm_pkg::NUM_SINES * erm_pkg::SINE_STEPS)) ?
		erm_pkg::sine_uop(k_q, s_q) :
		erm_pkg::mat_uop(5'(pc_q - 6'(erm_pkg::NUM_SINES * erm_pkg::SINE_STEPS)));

	// folded quarter-turn fraction for sine/cosine ld_q
	always_comb begin
		case (ld_q[2:1])
			2'd0:    ang = roll_q;
			2'd1:    ang = pitch_q;
			default: ang = gam_q;
		endcase
		phase  = {ang, {(32-ANGLE_BITS){1'b0}}} + (ld_q[0] ? 32'h4000_0000 : 32'd0);
		zf     = {1'b0, phase[29:0]};
		zfold  = phase[30] ? erm_pkg::Q30_ONE - zf : zf;
		ld_neg = phase[31] ^ (ld_q == 3'(erm_pkg::A_SB));
	end

	always_comb begin
		dsum = {base_depth_q[31], base_depth_q} + {sample.user_scaling[31], sample.user_scaling};
		if (dsum[32] != dsum[31])
			dsat = dsum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else
			dsat = dsum[31:0];
	end

	always_comb begin
		alu_ctl.en    = (state_q == S_RUN) && (ph_q == 2'd1);
		alu_ctl.op    = uop.op;
		alu_ctl.a_src = uop.a_src;
		alu_ctl.neg   = uop.use_flag && neg_q[uop.flag_idx];
		raddr_a = (state_q == S_COPY) ? erm_pkg::entry_addr(cp_q) : uop.a_addr;
		raddr_b = uop.b_addr;
		we      = (state_q == S_LOAD) || ((state_q == S_RUN) && (ph_q == 2'd2));
		waddr   = (state_q == S_LOAD) ? erm_pkg::addr_t'(ld_q) : uop.dst;
		wdata   = (state_q == S_LOAD) ? erm_pkg::word_t'({3'b000, zfold}) : alu_res;
		coef_full = erm_pkg::to_coef(rd_a, COEF_BITS);
		wr_idx  = cp_q - 4'd1;
	end

	erm_scratch u_scratch (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	erm_alu u_alu (
		.clk    (clk),
		.ctl    (alu_ctl),
		.a_mem  (rd_a),
		.b_mem  (rd_b),
		.result (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ld_q         <= '0;
			pc_q         <= '0;
			k_q          <= '0;
			s_q          <= '0;
			ph_q         <= '0;
			cp_q         <= '0;
			upd_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			neg_q        <= '0;
			base_depth_q <= erm_pkg::BASE_DEPTH_RST;
			depth_q      <= erm_pkg::BASE_DEPTH_RST;
			for (int i = 0; i < erm_pkg::NUM_ENTRIES; i++)
				r_q[i] <= rst_full[i][COEF_BITS-1:0];
		end else begin
			if (cfg.valid && cfg.ready)
				base_depth_q <= cfg.data;
			if (result.valid && result.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						roll_q      <= sample.roll_angle;
						pitch_q     <= sample.pitch_angle;
						gam_q       <= sample.user_rotation - sample.yaw_angle;
						upd_q       <= sample.sticker_present;
						depth_new_q <= dsat;
						ld_q        <= '0;
						state_q     <= sample.sticker_present ? S_LOAD : S_WAIT;
					end
				end
				S_LOAD: begin
					neg_q[ld_q] <= ld_neg;
					ld_q        <= ld_q + 3'd1;
					if (ld_q == 3'(erm_pkg::NUM_SINES - 1)) begin
						pc_q    <= '0;
						k_q     <= '0;
						s_q     <= '0;
						ph_q    <= '0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					// read, multiply, write back
					ph_q <= (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
					if (ph_q == 2'd2) begin
						pc_q <= pc_q + 6'd1;
						if (s_q == 3'(erm_pkg::SINE_STEPS - 1)) begin
							s_q <= '0;
							k_q <= k_q + 3'd1;
						end else begin
							s_q <= s_q + 3'd1;
						end
						if (pc_q == 6'(erm_pkg::NUM_UOPS - 1))
							state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					// hold until the previous result is taken
					if (!out_valid_q) begin
						if (upd_q) begin
							cp_q    <= '0;
							state_q <= S_COPY;
						end else begin
							out_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end
					end
				end
				S_COPY: begin
					cp_q <= cp_q + 4'd1;
					if (cp_q != 4'd0)
						r_q[wr_idx] <= coef_full[COEF_BITS-1:0];
					if (cp_q == 4'(erm_pkg::NUM_ENTRIES)) begin
						depth_q     <= depth_new_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid        = out_valid_q;
	assign result.r00          = r_q[0];
	assign result.r01          = r_q[1];
	assign result.r02          = r_q[2];
	assign result.r10          = r_q[3];
	assign result.r11          = r_q[4];
	assign result.r12          = r_q[5];
	assign result.r20          = r_q[6];
	assign result.r21          = r_q[7];
	assign result.r22          = r_q[8];
	assign result.depth_offset = depth_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !sample.ready)
		else $error("accepted a request while busy");

	a_copy_no_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COPY) |-> !out_valid_q)
		else $error("result overwritten while pending");

	a_alu_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		alu_ctl.en |-> (state_q == S_RUN))
		else $error("shared unit issued outside the program");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (pc_q < 6'(erm_pkg::NUM_UOPS)))
		else $error("program counter out of range");

endmodule

// ===== rtl/erm_scratch.sv =====
// ----------------------------------------------------------------------------
// erm_scratch: operand scratch memory
// Sixteen words, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module erm_scratch (
	input  logic           clk,
	input  logic           we,
	input  erm_pkg::addr_t waddr,
	input  erm_pkg::word_t wdata,
	input  erm_pkg::addr_t raddr_a,
	input  erm_pkg::addr_t raddr_b,
	output erm_pkg::word_t rdata_a,
	output erm_pkg::word_t rdata_b
);

	erm_pkg::word_t mem [2**erm_pkg::ADDR_W];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/erm_alu.sv =====
// ----------------------------------------------------------------------------
// erm_alu: shared multiply / add unit
// Sign-magnitude Q30 multiply with truncation or rounding, plus add and
// subtract. The product, sum, op and sign are registered when enabled; the
// result is formed combinationally from those registers.
// ----------------------------------------------------------------------------
module erm_alu (
	input  logic              clk,
	input  erm_pkg::alu_ctl_t ctl,
	input  erm_pkg::word_t    a_mem,
	input  erm_pkg::word_t    b_mem,
	output erm_pkg::word_t    result
);

	localparam int PW = 2 * erm_pkg::MAG_W;

	erm_pkg::word_t              a_opnd;
	erm_pkg::word_t              a_abs;
	erm_pkg::word_t              b_abs;
	logic [PW-1:0]               prod_q;
	erm_pkg::word_t              sum_q;
	erm_pkg::op_t                op_q;
	logic                        neg_q;
	logic [PW:0]                 rounded;
	erm_pkg::word_t              mres;

	always_comb begin
		unique case (ctl.a_src)
			erm_pkg::SRC_KA:   a_opnd = erm_pkg::K_SIN_A;
			erm_pkg::SRC_KB:   a_opnd = erm_pkg::K_SIN_B;
			erm_pkg::SRC_KC:   a_opnd = erm_pkg::K_SIN_C;
			erm_pkg::SRC_ZERO: a_opnd = '0;
			default:           a_opnd = a_mem;
		endcase
		a_abs = a_opnd[erm_pkg::WORD_W-1] ? -a_opnd : a_opnd;
		b_abs = b_mem[erm_pkg::WORD_W-1] ? -b_mem : b_mem;
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			prod_q <= a_abs[erm_pkg::MAG_W-1:0] * b_abs[erm_pkg::MAG_W-1:0];
			sum_q  <= (ctl.op == erm_pkg::OP_ADD) ? a_opnd + b_mem : a_opnd - b_mem;
			op_q   <= ctl.op;
			neg_q  <= a_opnd[erm_pkg::WORD_W-1] ^ b_mem[erm_pkg::WORD_W-1] ^ ctl.neg;
		end
	end

	always_comb begin
		rounded = {1'b0, prod_q} +
			((op_q == erm_pkg::OP_MULR) ? (PW+1)'(1) << 29 : '0);
		mres = erm_pkg::word_t'(rounded[PW:30]);
		case (op_q)
			erm_pkg::OP_MULT,
			erm_pkg::OP_MULR: result = neg_q ? -mres : mres;
			default:          result = sum_q;
		endcase
	end

endmodule
